[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[sv/cst_pkg.sv]
// ---------------------------------------------------------------------------
// cst_pkg
// Types, constants and character classes of the stream tokenizer.
// ---------------------------------------------------------------------------
package cst_pkg;

   localparam int CHAR_BITS        = 8;
   localparam int LINE_BITS        = 24;
   localparam int COL_BITS         = 16;
   localparam int TAB_BITS         = 7;
   localparam int TAB_RESET        = 8;
   localparam int HELD_SPACE_DEPTH = 15;
   localparam int HELD_IDX_BITS    = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
   localparam int HELD_CNT_BITS    = $clog2(HELD_SPACE_DEPTH + 1);
   localparam int DIV_CNT_BITS     = $clog2(COL_BITS);

   localparam logic [LINE_BITS-1:0] LINE_MAX = '1;
   localparam logic [COL_BITS-1:0]  COL_MAX  = '1;

   typedef logic [CHAR_BITS-1:0] char_type;

   localparam char_type CH_NUL    = 8'h00;
   localparam char_type CH_TAB    = 8'h09;
   localparam char_type CH_LF     = 8'h0A;
   localparam char_type CH_SPACE  = 8'h20;
   localparam char_type CH_QUOTE  = 8'h22;
   localparam char_type CH_DOT    = 8'h2E;
   localparam char_type CH_ZERO   = 8'h30;
   localparam char_type CH_NINE   = 8'h39;
   localparam char_type CH_BSLASH = 8'h5C;
   localparam char_type CH_BTICK  = 8'h60;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_STRING,
      MODE_ESCAPE,
      MODE_INTEGER,
      MODE_FRACTION,
      MODE_IDENT
   } lex_mode_type;

   typedef enum logic [2:0] {
      KIND_PUNCT,
      KIND_STRING,
      KIND_INTEGER,
      KIND_FRACTION,
      KIND_IDENT,
      KIND_EOF
   } token_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TAB,
      ST_PLAN,
      ST_CLOSE,
      ST_FLUSH,
      ST_CHAR,
      ST_MARK
   } ctrl_state_type;

   typedef enum logic [1:0] {
      SEL_CLOSE,
      SEL_FLUSH,
      SEL_CHAR,
      SEL_MARK
   } item_sel_type;

   // Result items one source byte produces, in emission order.
   typedef struct packed {
      logic do_close;
      logic do_flush;
      logic do_char;
      logic do_mark;
   } plan_type;

   typedef struct packed {
      logic         req_ready;
      logic         take;
      logic         tab_step;
      logic         plan;
      logic         emit;
      item_sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic     take_tab;
      logic     tab_last;
      plan_type plan_now;
      plan_type plan_q;
      logic     flush_last;
      logic     out_free;
   } status_type;

   function automatic logic is_punct(input char_type c);
      logic r;
      case (c) inside
         "!", "@", "#", "$", "%", "^", "&", "*", "(", ")", "-", "=", "+",
         "[", "]", "{", "}", ";", ":", ",", "<", ">", "/", "?", "~",
         CH_BTICK: r = 1'b1;
         default:  r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic is_space(input char_type c);
      return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB);
   endfunction

   function automatic logic is_digit(input char_type c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic char_type decode_escape(input char_type c);
      char_type r;
      unique case (c)
         "a":     r = 8'h07;
         "b":     r = 8'h08;
         "f":     r = 8'h0C;
         "n":     r = 8'h0A;
         "r":     r = 8'h0D;
         "t":     r = 8'h09;
         "v":     r = 8'h0B;
         default: r = c;
      endcase
      return r;
   endfunction

   function automatic token_kind_type mode_kind(input lex_mode_type m);
      token_kind_type k;
      unique case (m)
         MODE_INTEGER:  k = KIND_INTEGER;
         MODE_FRACTION: k = KIND_FRACTION;
         MODE_IDENT:    k = KIND_IDENT;
         default:       k = KIND_STRING;
      endcase
      return k;
   endfunction

endpackage

[sv/cst_req_if.sv]
// ---------------------------------------------------------------------------
// cst_req_if
// Source byte channel: valid/ready with byte and end-of-input flag.
// ---------------------------------------------------------------------------
interface cst_req_if;
   logic                        valid;
   logic                        ready;
   logic [cst_pkg::CHAR_BITS-1:0] char_in;
   logic                        end_of_input;

   modport source (output valid, output char_in, output end_of_input, input ready);
   modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

[sv/cst_rsp_if.sv]
// ---------------------------------------------------------------------------
// cst_rsp_if
// Token item channel: valid/ready with character, marker and position.
// ---------------------------------------------------------------------------
interface cst_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cst_pkg::CHAR_BITS-1:0] char_out;
   logic                          has_char;
   logic [2:0]                    token_kind;
   logic                          token_last;
   logic [cst_pkg::LINE_BITS-1:0] line_no;
   logic [cst_pkg::COL_BITS-1:0]  column_no;
   logic                          space_overflow;

   modport source (output valid, output char_out, output has_char, output token_kind,
                   output token_last, output line_no, output column_no,
                   output space_overflow, input ready);
   modport sink   (input valid, input char_out, input has_char, input token_kind,
                   input token_last, input line_no, input column_no,
                   input space_overflow, output ready);
endinterface

[sv/cst_ctrl.sv]
// ---------------------------------------------------------------------------
// cst_ctrl
// Sequencer: takes a byte, runs the tab remainder, plans, emits items.
// ---------------------------------------------------------------------------
module cst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  cst_pkg::status_type status,
   output cst_pkg::cmd_type    cmd
);
   import cst_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;
   plan_type       rest;

   // First pending item of a plan, or back to idle.
   function automatic ctrl_state_type phase_from(input plan_type p);
      ctrl_state_type s;
      if (p.do_close) begin
         s = ST_CLOSE;
      end else if (p.do_flush) begin
         s = ST_FLUSH;
      end else if (p.do_char) begin
         s = ST_CHAR;
      end else if (p.do_mark) begin
         s = ST_MARK;
      end else begin
         s = ST_IDLE;
      end
      return s;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      rest     = status.plan_q;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = status.take_tab ? ST_TAB : ST_PLAN;
            end
         end
         ST_TAB: begin
            if (status.tab_last) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            state_in = phase_from(status.plan_now);
         end
         ST_CLOSE: begin
            if (status.out_free) begin
               rest.do_close = 1'b0;
               state_in      = phase_from(rest);
            end
         end
         ST_FLUSH: begin
            if (status.out_free && status.flush_last) begin
               rest.do_close = 1'b0;
               rest.do_flush = 1'b0;
               state_in      = phase_from(rest);
            end
         end
         ST_CHAR: begin
            if (status.out_free) begin
               rest.do_close = 1'b0;
               rest.do_flush = 1'b0;
               rest.do_char  = 1'b0;
               state_in      = phase_from(rest);
            end
         end
         ST_MARK: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = 1'b1;
            cmd.take      = req_valid;
         end
         ST_TAB: begin
            cmd.tab_step = 1'b1;
         end
         ST_PLAN: begin
            cmd.plan = 1'b1;
         end
         ST_CLOSE: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_CLOSE;
         end
         ST_FLUSH: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_FLUSH;
         end
         ST_CHAR: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_CHAR;
         end
         ST_MARK: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_MARK;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

[sv/cst_datapath.sv]
// ---------------------------------------------------------------------------
// cst_datapath
// Position tracking, tab remainder unit, lexer state, held spaces, output.
// ---------------------------------------------------------------------------
module cst_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  cst_pkg::cmd_type                    cmd,
   output cst_pkg::status_type                 status,
   input  cst_pkg::char_type                   req_char_in,
   input  logic                                req_end_of_input,
   input  logic                                csr_wr_en,
   input  logic [cst_pkg::TAB_BITS-1:0]        csr_wr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output cst_pkg::char_type                   rsp_char_out,
   output logic                                rsp_has_char,
   output logic [2:0]                          rsp_token_kind,
   output logic                                rsp_token_last,
   output logic [cst_pkg::LINE_BITS-1:0]       rsp_line_no,
   output logic [cst_pkg::COL_BITS-1:0]        rsp_column_no,
   output logic                                rsp_space_overflow
);
   import cst_pkg::*;

   // configuration and position
   logic [TAB_BITS-1:0]      tab_stop_ff,  tab_stop_in;
   logic [LINE_BITS-1:0]     cur_line_ff,  cur_line_in;
   logic [COL_BITS-1:0]      cur_col_ff,   cur_col_in;
   logic [TAB_BITS-1:0]      tab_div;

   // tab remainder unit
   logic [COL_BITS-1:0]      div_num_ff,   div_num_in;
   logic [TAB_BITS-1:0]      div_rem_ff,   div_rem_in;
   logic [DIV_CNT_BITS-1:0]  div_cnt_ff,   div_cnt_in;
   logic [TAB_BITS:0]        rem_shift;
   logic [TAB_BITS:0]        rem_diff;
   logic [TAB_BITS-1:0]      rem_next;
   logic [COL_BITS:0]        tab_sum;
   logic [COL_BITS-1:0]      tab_col;
   logic                     take_tab;
   logic                     tab_last;

   // lexer state
   lex_mode_type             mode_ff,      mode_in;
   logic [HELD_CNT_BITS-1:0] held_cnt_ff,  held_cnt_in;
   logic                     ovf_ff,       ovf_in;
   char_type                 item_char_ff, item_char_in;
   logic                     item_eof_ff,  item_eof_in;

   // held spaces
   char_type                 held_ch_ff   [HELD_SPACE_DEPTH];
   logic [LINE_BITS-1:0]     held_line_ff [HELD_SPACE_DEPTH];
   logic [COL_BITS-1:0]      held_col_ff  [HELD_SPACE_DEPTH];
   logic [HELD_IDX_BITS-1:0] held_wr_idx;
   logic                     held_we;

   // plan decode and latched plan
   plan_type                 plan_nx;
   char_type                 char_nx;
   token_kind_type           mark_nx;
   token_kind_type           word_kind;
   lex_mode_type             mode_nx;
   logic [HELD_CNT_BITS-1:0] cnt_nx;
   logic                     ovf_nx;
   plan_type                 plan_q_ff,     plan_q_in;
   token_kind_type           close_kind_ff, close_kind_in;
   logic                     close_ovf_ff,  close_ovf_in;
   char_type                 char_val_ff,   char_val_in;
   token_kind_type           mark_kind_ff,  mark_kind_in;
   logic [HELD_CNT_BITS-1:0] flush_n_ff,    flush_n_in;
   logic [HELD_IDX_BITS-1:0] flush_idx_ff,  flush_idx_in;
   logic                     flush_last;

   // output register
   logic                     out_valid_ff, out_valid_in;
   char_type                 out_char_ff,  out_char_in;
   logic                     out_has_ff,   out_has_in;
   token_kind_type           out_kind_ff,  out_kind_in;
   logic                     out_last_ff,  out_last_in;
   logic [LINE_BITS-1:0]     out_line_ff,  out_line_in;
   logic [COL_BITS-1:0]      out_col_ff,   out_col_in;
   logic                     out_ovf_ff,   out_ovf_in;
   logic                     out_free;

   assign tab_div  = (tab_stop_ff == '0) ? TAB_BITS'(1) : tab_stop_ff;
   assign take_tab = !req_end_of_input && (req_char_in == CH_TAB);
   assign tab_last = (div_cnt_ff == DIV_CNT_BITS'(COL_BITS - 1));

   // restoring remainder, one quotient bit per step
   assign rem_shift = {div_rem_ff, div_num_ff[COL_BITS-1]};
   assign rem_diff  = rem_shift - {1'b0, tab_div};
   assign rem_next  = (rem_shift >= {1'b0, tab_div}) ? rem_diff[TAB_BITS-1:0]
                                                     : rem_shift[TAB_BITS-1:0];
   assign tab_sum   = {1'b0, cur_col_ff} - (COL_BITS+1)'(rem_next)
                      + (COL_BITS+1)'(tab_div);
   assign tab_col   = tab_sum[COL_BITS] ? COL_MAX : tab_sum[COL_BITS-1:0];

   always_comb begin
      tab_stop_in = csr_wr_en ? csr_wr_data : tab_stop_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      if (cmd.take && !req_end_of_input && !take_tab) begin
         if (cur_col_ff != COL_MAX) begin
            cur_col_in = cur_col_ff + 1'b1;
         end
         if (req_char_in == CH_LF) begin
            cur_col_in = COL_BITS'(1);
            if (cur_line_ff != LINE_MAX) begin
               cur_line_in = cur_line_ff + 1'b1;
            end
         end
      end else if (cmd.tab_step && tab_last) begin
         cur_col_in = tab_col;
      end
   end

   always_comb begin
      div_num_in = div_num_ff;
      div_rem_in = div_rem_ff;
      div_cnt_in = div_cnt_ff;
      if (cmd.take) begin
         div_num_in = cur_col_ff;
         div_rem_in = '0;
         div_cnt_in = '0;
      end else if (cmd.tab_step) begin
         div_num_in = {div_num_ff[COL_BITS-2:0], 1'b0};
         div_rem_in = rem_next;
         div_cnt_in = div_cnt_ff + 1'b1;
      end
   end

   assign item_char_in = cmd.take ? req_char_in : item_char_ff;
   assign item_eof_in  = cmd.take ? req_end_of_input : item_eof_ff;
   assign word_kind    = mode_kind(mode_ff);

   // what the latched byte does to the lexer
   always_comb begin
      plan_nx = '0;
      char_nx = item_char_ff;
      mark_nx = KIND_PUNCT;
      mode_nx = mode_ff;
      cnt_nx  = held_cnt_ff;
      ovf_nx  = ovf_ff;
      held_we = 1'b0;
      if (item_eof_ff) begin
         plan_nx.do_close = (mode_ff != MODE_IDLE);
         plan_nx.do_mark  = 1'b1;
         mark_nx          = KIND_EOF;
         mode_nx          = MODE_IDLE;
         cnt_nx           = '0;
         ovf_nx           = 1'b0;
      end else begin
         unique case (mode_ff) inside
            MODE_STRING: begin
               if (item_char_ff == CH_NUL || item_char_ff == CH_QUOTE) begin
                  plan_nx.do_close = 1'b1;
                  mode_nx          = MODE_IDLE;
                  cnt_nx           = '0;
                  ovf_nx           = 1'b0;
               end else if (item_char_ff == CH_BSLASH) begin
                  mode_nx = MODE_ESCAPE;
               end else begin
                  plan_nx.do_char = 1'b1;
               end
            end
            MODE_ESCAPE: begin
               if (item_char_ff == CH_NUL) begin
                  plan_nx.do_close = 1'b1;
                  mode_nx          = MODE_IDLE;
                  cnt_nx           = '0;
                  ovf_nx           = 1'b0;
               end else begin
                  plan_nx.do_char = 1'b1;
                  char_nx         = decode_escape(item_char_ff);
                  mode_nx         = MODE_STRING;
               end
            end
            MODE_INTEGER, MODE_FRACTION, MODE_IDENT: begin
               if (item_char_ff == CH_NUL) begin
                  plan_nx.do_close = 1'b1;
                  mode_nx          = MODE_IDLE;
                  cnt_nx           = '0;
                  ovf_nx           = 1'b0;
               end else if (is_punct(item_char_ff)) begin
                  plan_nx.do_close = 1'b1;
                  plan_nx.do_char  = 1'b1;
                  plan_nx.do_mark  = 1'b1;
                  mode_nx          = MODE_IDLE;
                  cnt_nx           = '0;
                  ovf_nx           = 1'b0;
               end else if (item_char_ff == CH_DOT) begin
                  plan_nx.do_char = 1'b1;
                  if (mode_ff == MODE_INTEGER) begin
                     mode_nx = MODE_FRACTION;
                  end else begin
                     // dot ends this word and opens an identifier
                     plan_nx.do_close = 1'b1;
                     mode_nx          = MODE_IDENT;
                     cnt_nx           = '0;
                     ovf_nx           = 1'b0;
                  end
               end else if (is_space(item_char_ff)) begin
                  if (mode_ff == MODE_IDENT) begin
                     if (held_cnt_ff < HELD_CNT_BITS'(HELD_SPACE_DEPTH)) begin
                        held_we = 1'b1;
                        cnt_nx  = held_cnt_ff + 1'b1;
                     end else begin
                        ovf_nx = 1'b1;
                     end
                  end
               end else begin
                  if (!is_digit(item_char_ff)) begin
                     mode_nx = MODE_IDENT;
                  end
                  plan_nx.do_flush = (held_cnt_ff != '0);
                  plan_nx.do_char  = 1'b1;
                  cnt_nx           = '0;
               end
            end
            MODE_IDLE: begin
               if (item_char_ff == CH_NUL || is_space(item_char_ff)) begin
                  mode_nx = MODE_IDLE;
               end else if (is_punct(item_char_ff)) begin
                  plan_nx.do_char = 1'b1;
                  plan_nx.do_mark = 1'b1;
               end else if (item_char_ff == CH_QUOTE) begin
                  mode_nx = MODE_STRING;
               end else begin
                  mode_nx         = is_digit(item_char_ff) ? MODE_INTEGER : MODE_IDENT;
                  cnt_nx          = '0;
                  ovf_nx          = 1'b0;
                  plan_nx.do_char = 1'b1;
               end
            end
            default: begin
               mode_nx = MODE_IDLE;
            end
         endcase
      end
   end

   assign held_wr_idx = held_cnt_ff[HELD_IDX_BITS-1:0];
   assign flush_last  = (HELD_CNT_BITS'(flush_idx_ff) == (flush_n_ff - 1'b1));

   always_comb begin
      mode_in       = mode_ff;
      held_cnt_in   = held_cnt_ff;
      ovf_in        = ovf_ff;
      plan_q_in     = plan_q_ff;
      close_kind_in = close_kind_ff;
      close_ovf_in  = close_ovf_ff;
      char_val_in   = char_val_ff;
      mark_kind_in  = mark_kind_ff;
      flush_n_in    = flush_n_ff;
      flush_idx_in  = flush_idx_ff;
      if (cmd.plan) begin
         mode_in       = mode_nx;
         held_cnt_in   = cnt_nx;
         ovf_in        = ovf_nx;
         plan_q_in     = plan_nx;
         close_kind_in = word_kind;
         close_ovf_in  = ovf_ff;
         char_val_in   = char_nx;
         mark_kind_in  = mark_nx;
         flush_n_in    = held_cnt_ff;
         flush_idx_in  = '0;
      end else if (cmd.emit && cmd.sel == SEL_FLUSH) begin
         flush_idx_in = flush_idx_ff + 1'b1;
      end
   end

   // output register: one result item at a time
   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_char_in  = out_char_ff;
      out_has_in   = out_has_ff;
      out_kind_in  = out_kind_ff;
      out_last_in  = out_last_ff;
      out_line_in  = out_line_ff;
      out_col_in   = out_col_ff;
      out_ovf_in   = out_ovf_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_line_in  = cur_line_ff;
         out_col_in   = cur_col_ff;
         out_ovf_in   = ovf_ff;
         unique case (cmd.sel)
            SEL_CLOSE: begin
               out_char_in = CH_NUL;
               out_has_in  = 1'b0;
               out_kind_in = close_kind_ff;
               out_last_in = 1'b1;
               out_ovf_in  = close_ovf_ff;
            end
            SEL_FLUSH: begin
               out_char_in = held_ch_ff[flush_idx_ff];
               out_has_in  = 1'b1;
               out_kind_in = KIND_PUNCT;
               out_last_in = 1'b0;
               out_line_in = held_line_ff[flush_idx_ff];
               out_col_in  = held_col_ff[flush_idx_ff];
            end
            SEL_CHAR: begin
               out_char_in = char_val_ff;
               out_has_in  = 1'b1;
               out_kind_in = KIND_PUNCT;
               out_last_in = 1'b0;
            end
            SEL_MARK: begin
               out_char_in = CH_NUL;
               out_has_in  = 1'b0;
               out_kind_in = mark_kind_ff;
               out_last_in = 1'b1;
            end
            default: begin
               out_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tab_stop_ff  <= TAB_BITS'(TAB_RESET);
         cur_line_ff  <= LINE_BITS'(1);
         cur_col_ff   <= '0;
         mode_ff      <= MODE_IDLE;
         held_cnt_ff  <= '0;
         ovf_ff       <= 1'b0;
         div_cnt_ff   <= '0;
         plan_q_ff    <= '0;
         flush_idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         tab_stop_ff  <= tab_stop_in;
         cur_line_ff  <= cur_line_in;
         cur_col_ff   <= cur_col_in;
         mode_ff      <= mode_in;
         held_cnt_ff  <= held_cnt_in;
         ovf_ff       <= ovf_in;
         div_cnt_ff   <= div_cnt_in;
         plan_q_ff    <= plan_q_in;
         flush_idx_ff <= flush_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      item_char_ff  <= item_char_in;
      item_eof_ff   <= item_eof_in;
      close_kind_ff <= close_kind_in;
      close_ovf_ff  <= close_ovf_in;
      char_val_ff   <= char_val_in;
      mark_kind_ff  <= mark_kind_in;
      flush_n_ff    <= flush_n_in;
      out_char_ff   <= out_char_in;
      out_has_ff    <= out_has_in;
      out_kind_ff   <= out_kind_in;
      out_last_ff   <= out_last_in;
      out_line_ff   <= out_line_in;
      out_col_ff    <= out_col_in;
      out_ovf_ff    <= out_ovf_in;
      if (cmd.plan && held_we) begin
         held_ch_ff[held_wr_idx]   <= item_char_ff;
         held_line_ff[held_wr_idx] <= cur_line_ff;
         held_col_ff[held_wr_idx]  <= cur_col_ff;
      end
   end

   always_comb begin
      status            = '0;
      status.take_tab   = take_tab;
      status.tab_last   = tab_last;
      status.plan_now   = plan_nx;
      status.plan_q     = plan_q_ff;
      status.flush_last = flush_last;
      status.out_free   = out_free;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_char_out       = out_char_ff;
   assign rsp_has_char       = out_has_ff;
   assign rsp_token_kind     = out_kind_ff;
   assign rsp_token_last     = out_last_ff;
   assign rsp_line_no        = out_line_ff;
   assign rsp_column_no      = out_col_ff;
   assign rsp_space_overflow = out_ovf_ff;

endmodule

[sv/char_stream_tokenizer.sv]
// ---------------------------------------------------------------------------
// char_stream_tokenizer
// Streaming lexer with line/column tracking; emits token characters and
// kind markers.
// The first result of a byte is registered after the plan state; a tab
//   first runs the bit-serial column remainder unit.
// One byte at a time: a new byte is taken only once every result item of the
//   last is loaded, each waiting while rsp stalls; a tab adds the remainder steps (one remainder bit per cycle).
// Reset: synchronous; idle, line 1, column 0, tab stop 8; no clearing pass.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module char_stream_tokenizer (
   input  logic                          clock,
   input  logic                          reset,
   cst_req_if.sink                       req_bus,
   cst_rsp_if.source                     rsp_bus,
   input  logic                          csr_wr_en,
   input  logic [cst_pkg::TAB_BITS-1:0]  csr_wr_data
);
   import cst_pkg::*;

   // Controller and datapath talk only through these two bundles.
   cmd_type    cmd;
   status_type status;
   logic       req_xfer;

   // Controller: one byte at a time. Idle takes a transfer, a tab goes
   // through the remainder steps, the plan cycle decides the items, then
   // close marker, held spaces, character and trailing marker are emitted
   // in that order, each waiting for a free output register.
   cst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .status    (status),
      .cmd       (cmd)
   );

   assign req_bus.ready = cmd.req_ready;
   assign req_xfer      = req_bus.valid && req_bus.ready;

   // Datapath: position counters, tab remainder unit, lexer mode, held
   // whitespace store (byte plus position) and the output register.
   cst_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_char_in        (req_bus.char_in),
      .req_end_of_input   (req_bus.end_of_input),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .rsp_ready          (rsp_bus.ready),
      .rsp_valid          (rsp_bus.valid),
      .rsp_char_out       (rsp_bus.char_out),
      .rsp_has_char       (rsp_bus.has_char),
      .rsp_token_kind     (rsp_bus.token_kind),
      .rsp_token_last     (rsp_bus.token_last),
      .rsp_line_no        (rsp_bus.line_no),
      .rsp_column_no      (rsp_bus.column_no),
      .rsp_space_overflow (rsp_bus.space_overflow)
   );

   // A result is never loaded over one that still waits.
   `ASSERT_IMPLY(a_emit_into_free, clock, reset, cmd.emit, status.out_free)
   // A tab transfer stalls the input while the remainder runs.
   `ASSERT_NEXT(a_tab_stalls, clock, reset, req_xfer && status.take_tab, !req_bus.ready)
   // Markers close tokens and carry no character.
   `ASSERT_IMPLY(a_marker_no_char, clock, reset, rsp_bus.valid && rsp_bus.token_last, !rsp_bus.has_char)

endmodule

[dv/char_stream_tokenizer_test.sv]
// ---------------------------------------------------------------------------
// char_stream_tokenizer_test
// Self-checking bench for the stream tokenizer. A short stimulus table walks
// reset, extreme bytes and every lexer mode. Randomly shaped token text then
// follows under several tab stops, the zero tab stop and a stop of 64
// included. Each byte transfer feeds a lexer model in the bench, and every
// token item transfer is checked field by field against its queued
// prediction. Both channels idle and stall at random.
// ---------------------------------------------------------------------------
module char_stream_tokenizer_test;
   import cst_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 4;
   localparam int TIMEOUT      = 10_000_000;
   // A byte with no token item may still be in the tab divider
   // (16 remainder steps and the plan state).
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 46;
   localparam int TAB_PHASES   = 5;
   localparam int STIM_ROWS    = 26;

   localparam logic [TAB_BITS-1:0] TAB_PLAN [TAB_PHASES] = '{7'd1, 7'd64, 7'd0, 7'd3, 7'd13};

   // Backtick is checked on its own.
   localparam string PUNCT_CHARS = "!@#$%^&*()-=+[]{};:,<>/?~";
   localparam string ESC_PICKS   = "abfnrtvqz0\\\"";

   // One token item as seen on the result channel.
   typedef struct packed {
      logic [CHAR_BITS-1:0] char_out;
      logic                 has_char;
      logic [2:0]           token_kind;
      logic                 token_last;
      logic [LINE_BITS-1:0] line_no;
      logic [COL_BITS-1:0]  column_no;
      logic                 space_overflow;
   } token_item_type;

   // Whitespace held inside an identifier, with the position it had.
   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic [LINE_BITS-1:0] ln;
      logic [COL_BITS-1:0]  cl;
   } held_space_type;

   // A stimulus row; n_fixed > 0 means the token items are typed in below.
   typedef struct packed {
      logic [CHAR_BITS-1:0] ch;
      logic                 eoi;
      logic [1:0]           n_fixed;
      token_item_type       fix_a;
      token_item_type       fix_b;
   } stim_row_type;

   // Character items carry a zero kind, written as KIND_PUNCT.
   localparam stim_row_type STIM [STIM_ROWS] = '{
      // end of input right after reset: lone marker at line 1, column 0
      '{8'hA5, 1'b1, 2'd1,
        '{CH_NUL, 1'b0, KIND_EOF, 1'b1, 24'd1, 16'd0, 1'b0}, '0},
      // one-character punctuation token at column 1
      '{"!", 1'b0, 2'd2,
        '{"!", 1'b1, KIND_PUNCT, 1'b0, 24'd1, 16'd1, 1'b0},
        '{CH_NUL, 1'b0, KIND_PUNCT, 1'b1, 24'd1, 16'd1, 1'b0}},
      '{CH_BTICK,  1'b0, 2'd0, '0, '0},   // last punctuation byte
      '{CH_NUL,    1'b0, 2'd0, '0, '0},   // zero byte skipped between tokens
      '{CH_QUOTE,  1'b0, 2'd0, '0, '0},   // open string
      '{CH_BSLASH, 1'b0, 2'd0, '0, '0},
      '{"n",       1'b0, 2'd0, '0, '0},   // decoded escape
      '{8'hFF,     1'b0, 2'd0, '0, '0},
      '{CH_BSLASH, 1'b0, 2'd0, '0, '0},
      '{CH_NUL,    1'b0, 2'd0, '0, '0},   // zero after backslash closes string
      '{"7",       1'b0, 2'd0, '0, '0},   // integer
      '{CH_TAB,    1'b0, 2'd0, '0, '0},   // skipped inside a number
      '{CH_DOT,    1'b0, 2'd0, '0, '0},   // integer becomes fraction
      '{"5",       1'b0, 2'd0, '0, '0},
      '{CH_DOT,    1'b0, 2'd0, '0, '0},   // closes fraction, opens identifier
      '{CH_SPACE,  1'b0, 2'd0, '0, '0},   // held
      '{"x",       1'b0, 2'd0, '0, '0},   // held space flushed first
      '{CH_LF,     1'b0, 2'd0, '0, '0},   // held, trailing
      '{";",       1'b0, 2'd0, '0, '0},   // closes identifier, then punct
      '{"0",       1'b0, 2'd0, '0, '0},
      '{"a",       1'b0, 2'd0, '0, '0},   // letter turns number into identifier
      '{CH_NUL,    1'b0, 2'd0, '0, '0},   // zero closes identifier
      '{8'hFF,     1'b0, 2'd0, '0, '0},   // top byte opens identifier
      '{8'h00,     1'b1, 2'd0, '0, '0},   // end of input inside identifier
      '{CH_QUOTE,  1'b0, 2'd0, '0, '0},
      '{8'h5A,     1'b1, 2'd0, '0, '0}    // end of input inside string
   };

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [TAB_BITS-1:0] csr_wr_data;

   cst_req_if req_if ();
   cst_rsp_if rsp_if ();

   char_stream_tokenizer uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_if),
      .rsp_bus     (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // -------------------------------------------------------------------------
   // Lexer model state
   // -------------------------------------------------------------------------
   logic [TAB_BITS-1:0]  tab_stop;
   lex_mode_type         mode;
   logic [LINE_BITS-1:0] cur_line;
   logic [COL_BITS-1:0]  cur_col;
   held_space_type       held [HELD_SPACE_DEPTH];
   int                   held_count;
   logic                 overflow_seen;

   token_item_type lexed_items [$];    // items of the byte just lexed
   token_item_type pending_tokens [$]; // items still owed by the block

   int          mismatches = 0;
   int unsigned sent_items = 0;
   int          req_calm = 0;
   int          rsp_calm = 0;

   function automatic logic punct_byte(input logic [CHAR_BITS-1:0] c);
      logic hit;
      hit = (c == CH_BTICK);
      for (int i = 0; i < PUNCT_CHARS.len(); i++)
         if (PUNCT_CHARS[i] == c) hit = 1'b1;
      return hit;
   endfunction

   function automatic logic blank_byte(input logic [CHAR_BITS-1:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_LF;
   endfunction

   function automatic logic digit_byte(input logic [CHAR_BITS-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic logic [CHAR_BITS-1:0] unescape(input logic [CHAR_BITS-1:0] c);
      case (c)
         "a":     return 8'h07;
         "b":     return 8'h08;
         "f":     return 8'h0C;
         "n":     return 8'h0A;
         "r":     return 8'h0D;
         "t":     return 8'h09;
         "v":     return 8'h0B;
         default: return c;
      endcase
   endfunction

   function automatic token_kind_type word_kind(input lex_mode_type m);
      case (m)
         MODE_INTEGER:  return KIND_INTEGER;
         MODE_FRACTION: return KIND_FRACTION;
         MODE_IDENT:    return KIND_IDENT;
         default:       return KIND_STRING;
      endcase
   endfunction

   function automatic void emit(input logic [CHAR_BITS-1:0] ch, input logic has,
                                input logic [2:0] kind, input logic last,
                                input logic [LINE_BITS-1:0] ln,
                                input logic [COL_BITS-1:0] cl);
      token_item_type t;
      t.char_out       = ch;
      t.has_char       = has;
      t.token_kind     = kind;
      t.token_last     = last;
      t.line_no        = ln;
      t.column_no      = cl;
      t.space_overflow = overflow_seen;
      lexed_items      = {lexed_items, t};
   endfunction

   // Queue an item the block owes.
   function automatic void owe_item(input token_item_type t);
      pending_tokens = {pending_tokens, t};
   endfunction

   function automatic void emit_char(input logic [CHAR_BITS-1:0] c);
      emit(c, 1'b1, KIND_PUNCT, 1'b0, cur_line, cur_col);
   endfunction

   function automatic void close_token(input token_kind_type kind);
      emit(CH_NUL, 1'b0, kind, 1'b1, cur_line, cur_col);
      held_count    = 0;
      overflow_seen = 1'b0;
      mode          = MODE_IDLE;
   endfunction

   function automatic void advance_column(input logic [CHAR_BITS-1:0] c);
      int unsigned stride;
      int unsigned nxt;
      stride = (tab_stop == '0) ? 1 : tab_stop;
      if (c == CH_TAB) begin
         nxt     = (cur_col / stride + 1) * stride;
         cur_col = (nxt > COL_MAX) ? COL_MAX : nxt[COL_BITS-1:0];
      end else if (cur_col != COL_MAX) begin
         cur_col++;
      end
      if (c == CH_LF) begin
         cur_col = COL_BITS'(1);
         if (cur_line != LINE_MAX) cur_line++;
      end
   endfunction

   function automatic void open_token(input logic [CHAR_BITS-1:0] c);
      if (c == CH_NUL || blank_byte(c)) begin
         // nothing between tokens
      end else if (punct_byte(c)) begin
         emit_char(c);
         emit(CH_NUL, 1'b0, KIND_PUNCT, 1'b1, cur_line, cur_col);
      end else if (c == CH_QUOTE) begin
         mode = MODE_STRING;
      end else begin
         mode          = digit_byte(c) ? MODE_INTEGER : MODE_IDENT;
         held_count    = 0;
         overflow_seen = 1'b0;
         emit_char(c);
      end
   endfunction

   // Byte inside a number or identifier.
   function automatic void word_byte(input logic [CHAR_BITS-1:0] c);
      if (c == CH_NUL) begin
         close_token(word_kind(mode));
      end else if (punct_byte(c)) begin
         close_token(word_kind(mode));
         open_token(c);
      end else if (c == CH_DOT) begin
         if (mode == MODE_INTEGER) begin
            mode = MODE_FRACTION;
            emit_char(c);
         end else begin
            close_token(word_kind(mode));
            open_token(c);
         end
      end else if (blank_byte(c)) begin
         if (mode == MODE_IDENT) begin
            if (held_count < HELD_SPACE_DEPTH) begin
               held[held_count] = '{c, cur_line, cur_col};
               held_count++;
            end else begin
               overflow_seen = 1'b1;
            end
         end
      end else begin
         if (!digit_byte(c)) mode = MODE_IDENT;
         for (int i = 0; i < held_count; i++)
            emit(held[i].ch, 1'b1, KIND_PUNCT, 1'b0, held[i].ln, held[i].cl);
         held_count = 0;
         emit_char(c);
      end
   endfunction

   function automatic void lex_byte(input logic [CHAR_BITS-1:0] c, input logic eoi);
      if (eoi) begin
         if (mode != MODE_IDLE) close_token(word_kind(mode));
         emit(CH_NUL, 1'b0, KIND_EOF, 1'b1, cur_line, cur_col);
         mode          = MODE_IDLE;
         held_count    = 0;
         overflow_seen = 1'b0;
      end else begin
         advance_column(c);
         case (mode)
            MODE_STRING: begin
               if (c == CH_NUL || c == CH_QUOTE) close_token(KIND_STRING);
               else if (c == CH_BSLASH) mode = MODE_ESCAPE;
               else emit_char(c);
            end
            MODE_ESCAPE: begin
               if (c == CH_NUL) begin
                  close_token(KIND_STRING);
               end else begin
                  emit_char(unescape(c));
                  mode = MODE_STRING;
               end
            end
            MODE_INTEGER, MODE_FRACTION, MODE_IDENT: word_byte(c);
            default: begin
               mode = MODE_IDLE;
               open_token(c);
            end
         endcase
      end
   endfunction

   // -------------------------------------------------------------------------
   // Idle pattern: mostly short gaps, a few long ones, and calm stretches
   // -------------------------------------------------------------------------
   function automatic int pick_gap(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // -------------------------------------------------------------------------
   // Byte source
   // -------------------------------------------------------------------------
   // Runs at a rising edge; returns at the edge of the transfer, with valid
   // still high so that back-to-back bytes need no second assignment.
   task automatic push_byte(input stim_row_type row);
      int g;
      g = pick_gap(req_calm);
      if (g > 0) begin
         req_if.valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_if.valid        <= 1'b1;
      req_if.char_in      <= row.ch;
      req_if.end_of_input <= row.eoi;
      do @(posedge clock); while (req_if.ready !== 1'b1);

      // transfer taken: lex it and queue what the block owes
      lexed_items.delete();
      lex_byte(row.ch, row.eoi);
      if (row.n_fixed > 0) begin
         owe_item(row.fix_a);
         if (row.n_fixed > 1) owe_item(row.fix_b);
      end else begin
         foreach (lexed_items[i]) owe_item(lexed_items[i]);
      end
      sent_items++;
   endtask

   task automatic send_byte(input logic [CHAR_BITS-1:0] c, input logic eoi);
      stim_row_type row;
      row     = '0;
      row.ch  = c;
      row.eoi = eoi;
      push_byte(row);
   endtask

   // Wait until every owed item has arrived and the block has gone quiet.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (pending_tokens.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [CHAR_BITS-1:0] blank_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return CH_SPACE;
      if (r < 85) return CH_TAB;
      return CH_LF;
   endfunction

   function automatic logic [CHAR_BITS-1:0] punct_pick();
      int k;
      k = $urandom_range(0, PUNCT_CHARS.len());
      return (k == PUNCT_CHARS.len()) ? CH_BTICK : PUNCT_CHARS[k];
   endfunction

   // Byte that keeps an identifier going: mostly lower-case letters.
   function automatic logic [CHAR_BITS-1:0] word_char();
      logic [CHAR_BITS-1:0] c;
      if ($urandom_range(0, 3) != 0) begin
         c = 8'h61 + 8'($urandom_range(0, 25));
      end else begin
         do c = 8'($urandom_range(1, 255));
         while (punct_byte(c) || blank_byte(c) || digit_byte(c) || c == CH_DOT);
      end
      return c;
   endfunction

   // Ends a number or identifier in one of the ways the lexer knows,
   // or not at all.
   task automatic close_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) send_byte(punct_pick(), 1'b0);
      else if (pick < 60) send_byte(blank_char(), 1'b0);
      else if (pick < 75) send_byte(CH_NUL, 1'b0);
      else if (pick < 85) send_byte(8'($urandom_range(0, 255)), 1'b1);
      else if (pick < 95) send_byte(CH_DOT, 1'b0);
   endtask

   // -------------------------------------------------------------------------
   // Result sink: random ready
   // -------------------------------------------------------------------------
   initial begin : rsp_stall
      int g;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         g = pick_gap(rsp_calm);
         if (g > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (g) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // -------------------------------------------------------------------------
   // Checker: each item transfer against the oldest owed item
   // -------------------------------------------------------------------------
   function automatic string item_text(input token_item_type t);
      return $sformatf("ch=%h has=%b kind=%0d last=%b line=%0d col=%0d ovf=%b",
                       t.char_out, t.has_char, t.token_kind, t.token_last,
                       t.line_no, t.column_no, t.space_overflow);
   endfunction

   function automatic void note_mismatch(input string what, input token_item_type want,
                                         input token_item_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch (%s) at %0t: expected %s, got %s",
                  what, $realtime, item_text(want), item_text(got));
   endfunction

   always @(posedge clock) begin : check_tokens
      token_item_type got;
      token_item_type want;
      if (reset === 1'b0 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         got.char_out       = rsp_if.char_out;
         got.has_char       = rsp_if.has_char;
         got.token_kind     = rsp_if.token_kind;
         got.token_last     = rsp_if.token_last;
         got.line_no        = rsp_if.line_no;
         got.column_no      = rsp_if.column_no;
         got.space_overflow = rsp_if.space_overflow;
         if (pending_tokens.size() == 0) begin
            want = '0;
            note_mismatch("no item owed", want, got);
         end else begin
            want = pending_tokens.pop_front();
            if (got.char_out !== want.char_out || got.has_char !== want.has_char ||
                got.token_kind !== want.token_kind || got.token_last !== want.token_last ||
                got.line_no !== want.line_no || got.column_no !== want.column_no ||
                got.space_overflow !== want.space_overflow)
               note_mismatch("field", want, got);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int                   pick;
      int                   k;
      int unsigned          start_items;
      logic [CHAR_BITS-1:0] c;

      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.char_in      <= '0;
      req_if.end_of_input <= 1'b0;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;

      // model starts where the block comes out of reset
      tab_stop      = TAB_BITS'(TAB_RESET);
      mode          = MODE_IDLE;
      cur_line      = LINE_BITS'(1);
      cur_col       = '0;
      held_count    = 0;
      overflow_seen = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the reset tab stop.
      for (int i = 0; i < STIM_ROWS; i++) push_byte(STIM[i]);
      settle();

      // Random token text, one phase per tab stop. The register is only
      // written once the block has drained.
      for (int phase = 0; phase < TAB_PHASES; phase++) begin
         csr_wr_en   <= 1'b1;
         csr_wr_data <= TAB_PLAN[phase];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         tab_stop     = TAB_PLAN[phase];

         start_items = sent_items;
         while (sent_items - start_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               // identifier, with held whitespace runs; some overflow the store
               send_byte(($urandom_range(0, 5) == 0) ? CH_DOT : word_char(), 1'b0);
               repeat ($urandom_range(1, 8)) begin
                  k = $urandom_range(0, 9);
                  if (k < 5) send_byte(word_char(), 1'b0);
                  else if (k < 7) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                  else repeat (($urandom_range(0, 4) == 0) ? $urandom_range(14, 20)
                                                           : $urandom_range(1, 3))
                     send_byte(blank_char(), 1'b0);
               end
               close_word();
            end else if (pick < 50) begin
               // number: digits, dots, skipped blanks, now and then a letter
               send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
               repeat ($urandom_range(1, 6)) begin
                  k = $urandom_range(0, 9);
                  if (k < 6) send_byte(CH_ZERO + 8'($urandom_range(0, 9)), 1'b0);
                  else if (k < 8) send_byte(CH_DOT, 1'b0);
                  else if (k < 9) send_byte(blank_char(), 1'b0);
                  else send_byte(word_char(), 1'b0);
               end
               close_word();
            end else if (pick < 70) begin
               // string with escapes; closed by quote, zero, escaped zero or end
               send_byte(CH_QUOTE, 1'b0);
               repeat ($urandom_range(0, 8)) begin
                  if ($urandom_range(0, 9) < 7) begin
                     do c = 8'($urandom_range(1, 255));
                     while (c == CH_QUOTE || c == CH_BSLASH);
                     send_byte(c, 1'b0);
                  end else begin
                     send_byte(CH_BSLASH, 1'b0);
                     if ($urandom_range(0, 4) == 0) c = 8'($urandom_range(0, 255));
                     else c = ESC_PICKS[$urandom_range(0, ESC_PICKS.len() - 1)];
                     send_byte(c, 1'b0);
                  end
               end
               k = $urandom_range(0, 99);
               if (k < 80) begin
                  send_byte(CH_QUOTE, 1'b0);
               end else if (k < 88) begin
                  send_byte(CH_NUL, 1'b0);
               end else if (k < 94) begin
                  send_byte(CH_BSLASH, 1'b0);
                  send_byte(CH_NUL, 1'b0);
               end else begin
                  send_byte(8'($urandom_range(0, 255)), 1'b1);
               end
            end else if (pick < 80) begin
               repeat ($urandom_range(1, 3)) send_byte(punct_pick(), 1'b0);
            end else if (pick < 90) begin
               repeat ($urandom_range(1, 4)) send_byte(blank_char(), 1'b0);
            end else begin
               // noise: any byte, now and then an end of input
               repeat ($urandom_range(1, 4))
                  send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop if the block hangs or drops items.
   initial begin : watchdog
      #TIMEOUT;
      $display("FAIL");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/cst_pkg.sv
sv/cst_req_if.sv
sv/cst_rsp_if.sv
sv/cst_ctrl.sv
sv/cst_datapath.sv
sv/char_stream_tokenizer.sv
dv/char_stream_tokenizer_test.sv
